// ----- sv/sedge_pkg.sv -----
package sedge_pkg;

    // Pixel and coordinate widths fixed by the stream format.
    localparam int PIX_W    = 8;
    localparam int COORD_W  = 10;
    localparam int CFG_W    = 11;
    localparam int CFG_IDX_W = 2;

    // Column sum t+2m+b and column difference b-t of one window column.
    localparam int SUM_W  = PIX_W + 2;
    localparam int DIFF_W = PIX_W + 1;

    // Number of columns in the Sobel window.
    localparam int WIN_COLS = 3;

    // Size limits and register reset values.
    localparam int MAX_WIDTH_DEFAULT = 1024;
    localparam int MAX_HEIGHT        = 1024;
    localparam int MIN_SIZE          = 3;

    localparam logic [CFG_W-1:0] LINE_WIDTH_RESET   = CFG_W'(100);
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = CFG_W'(100);
    localparam logic [PIX_W-1:0] HIGH_THRESH_RESET  = PIX_W'(200);
    localparam logic [PIX_W-1:0] LOW_THRESH_RESET   = PIX_W'(100);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINE_WIDTH     = 2'd0,
        CFG_FRAME_HEIGHT   = 2'd1,
        CFG_HIGH_THRESHOLD = 2'd2,
        CFG_LOW_THRESHOLD  = 2'd3
    } cfg_reg_t;

    // One column of the 3x3 window, top row first.
    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } win_col_t;

    // One word of the line store: the two previous rows at a column.
    typedef struct packed {
        logic [PIX_W-1:0] older;
        logic [PIX_W-1:0] newer;
    } pix_pair_t;

endpackage

// ----- sv/sedge_line_store.sv -----
module sedge_line_store #(
    parameter int DEPTH = sedge_pkg::MAX_WIDTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 rd_en,
    input  logic [AW-1:0]        rd_addr,
    output sedge_pkg::pix_pair_t rd_data,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  sedge_pkg::pix_pair_t wr_data
);

    sedge_pkg::pix_pair_t mem [DEPTH];

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

endmodule

// ----- sv/sedge_cell.sv -----
module sedge_cell (
    input  logic                               clk,
    input  logic                               shift_en,
    input  sedge_pkg::win_col_t                col_in,
    output sedge_pkg::win_col_t                col_out,
    output logic [sedge_pkg::SUM_W-1:0]        col_sum,
    output logic signed [sedge_pkg::DIFF_W-1:0] col_diff
);

    sedge_pkg::win_col_t col_reg;

    // The column moves one place toward the left neighbor on each shift.
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            col_reg <= col_in;
        end
    end

    assign col_out = col_reg;

    // Weighted column sum feeds the horizontal gradient, the top-to-bottom
    // difference feeds the vertical gradient.
    assign col_sum  = {2'b00, col_reg.top} + {1'b0, col_reg.mid, 1'b0} + {2'b00, col_reg.bot};
    assign col_diff = $signed({1'b0, col_reg.bot}) - $signed({1'b0, col_reg.top});

endmodule

// ----- sv/sobel_edge_threshold_filter_top.sv -----
// Streaming 3x3 Sobel edge filter. Grey pixels enter in raster order at one
// pixel per clock; for every interior window center one result leaves with
// the inverted, thresholded gradient magnitude and the center coordinates,
// and border pixels produce nothing. An accepted pixel passes stage 1, the
// window and the gradient registers into the output register. The rate is
// set by the single line store, which is read at the pixel's column when
// the pixel is accepted and written back from stage 1; the window is a row
// of three column cells that shift once per pixel. A skid register behind
// the output register catches the result that arrives while the output is
// stalled, and the input is then held until the skid drains. The line store
// needs no clearing after reset: the first two rows of each frame fill it
// before any result reads it. Configuration must be written while idle.
module sobel_edge_threshold_filter_top #(
    parameter int MAX_WIDTH = sedge_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [sedge_pkg::PIX_W-1:0]      pixel,

    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [sedge_pkg::PIX_W-1:0]      edge_value,
    output logic [sedge_pkg::COORD_W-1:0]    center_row,
    output logic [sedge_pkg::COORD_W-1:0]    center_col,
    output logic                             last_of_frame,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sedge_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sedge_pkg::CFG_W-1:0]      cfg_data
);

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int LW_W   = ($clog2(MAX_WIDTH + 1) > sedge_pkg::CFG_W) ?
                            $clog2(MAX_WIDTH + 1) : sedge_pkg::CFG_W;
    localparam int RW     = sedge_pkg::COORD_W;
    localparam int PW     = sedge_pkg::PIX_W;
    localparam int GRAD_W = sedge_pkg::SUM_W + 1;
    localparam int NC     = sedge_pkg::WIN_COLS;

    typedef struct packed {
        logic [PW-1:0] level;
        logic [RW-1:0] row;
        logic [RW-1:0] col;
        logic          last;
    } result_t;

    typedef struct packed {
        logic [RW-1:0] row;
        logic [RW-1:0] col;
        logic          last;
    } meta_t;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [sedge_pkg::CFG_W-1:0] line_width_reg;
    logic [sedge_pkg::CFG_W-1:0] frame_height_reg;
    logic [PW-1:0]               high_thresh_reg;
    logic [PW-1:0]               low_thresh_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg   <= sedge_pkg::LINE_WIDTH_RESET;
            frame_height_reg <= sedge_pkg::FRAME_HEIGHT_RESET;
            high_thresh_reg  <= sedge_pkg::HIGH_THRESH_RESET;
            low_thresh_reg   <= sedge_pkg::LOW_THRESH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (sedge_pkg::cfg_reg_t'(cfg_index))
                sedge_pkg::CFG_LINE_WIDTH:     line_width_reg   <= cfg_data;
                sedge_pkg::CFG_FRAME_HEIGHT:   frame_height_reg <= cfg_data;
                sedge_pkg::CFG_HIGH_THRESHOLD: high_thresh_reg  <= cfg_data[PW-1:0];
                sedge_pkg::CFG_LOW_THRESHOLD:  low_thresh_reg   <= cfg_data[PW-1:0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Effective frame size, clamped to the supported range.
    // ------------------------------------------------------------------
    logic [LW_W-1:0]                 lw_ext;
    logic [LW_W-1:0]                 w_eff;
    logic [LW_W-1:0]                 w_last;
    logic [sedge_pkg::CFG_W-1:0]     h_eff;
    logic [sedge_pkg::CFG_W-1:0]     h_last;

    always_comb
    begin
        lw_ext = LW_W'(line_width_reg);
        if (lw_ext < LW_W'(sedge_pkg::MIN_SIZE))
        begin
            w_eff = LW_W'(sedge_pkg::MIN_SIZE);
        end
        else if (lw_ext > LW_W'(MAX_WIDTH))
        begin
            w_eff = LW_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = lw_ext;
        end
        w_last = w_eff - LW_W'(1);

        if (frame_height_reg < sedge_pkg::CFG_W'(sedge_pkg::MIN_SIZE))
        begin
            h_eff = sedge_pkg::CFG_W'(sedge_pkg::MIN_SIZE);
        end
        else if (frame_height_reg > sedge_pkg::CFG_W'(sedge_pkg::MAX_HEIGHT))
        begin
            h_eff = sedge_pkg::CFG_W'(sedge_pkg::MAX_HEIGHT);
        end
        else
        begin
            h_eff = frame_height_reg;
        end
        h_last = h_eff - sedge_pkg::CFG_W'(1);
    end

    // ------------------------------------------------------------------
    // Pipeline advance and input acceptance.
    // ------------------------------------------------------------------
    logic skid_valid_reg;
    logic out_valid_reg;
    logic adv;
    logic in_fire;

    assign adv      = !skid_valid_reg;
    assign in_ready = adv;
    assign in_fire  = in_valid && in_ready;

    // ------------------------------------------------------------------
    // Raster position of the incoming pixel.
    // ------------------------------------------------------------------
    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;
    logic          row_end;
    logic          frame_end;
    logic          emit;

    assign row_end   = LW_W'(col_reg) >= w_last;
    assign frame_end = row_end && (sedge_pkg::CFG_W'(row_reg) >= h_last);
    assign emit      = (row_reg >= RW'(2)) && (col_reg >= CW'(2));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_fire)
        begin
            if (row_end)
            begin
                col_reg <= '0;
                row_reg <= frame_end ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_reg <= col_reg + CW'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: line store read in flight, pixel and position held.
    // ------------------------------------------------------------------
    logic          s1_valid_reg;
    logic [PW-1:0] s1_px_reg;
    logic [CW-1:0] s1_col_reg;
    logic          s1_emit_reg;
    meta_t         s1_meta_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_px_reg        <= pixel;
            s1_col_reg       <= col_reg;
            s1_emit_reg      <= emit;
            s1_meta_reg.row  <= row_reg - RW'(1);
            s1_meta_reg.col  <= RW'(col_reg - CW'(1));
            s1_meta_reg.last <= frame_end;
        end
    end

    // The store holds the two previous rows; each pixel pushes its column
    // down by one row.
    sedge_pkg::pix_pair_t rd_pair;
    sedge_pkg::pix_pair_t wr_pair;
    logic                 s1_move;

    assign s1_move       = adv && s1_valid_reg;
    assign wr_pair.older = rd_pair.newer;
    assign wr_pair.newer = s1_px_reg;

    sedge_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_store (
        .clk     (clk),
        .rd_en   (in_fire),
        .rd_addr (col_reg),
        .rd_data (rd_pair),
        .wr_en   (s1_move),
        .wr_addr (s1_col_reg),
        .wr_data (wr_pair)
    );

    // ------------------------------------------------------------------
    // Window: a row of column cells, the newest column enters on the right.
    // ------------------------------------------------------------------
    sedge_pkg::win_col_t                 cell_in   [NC];
    sedge_pkg::win_col_t                 cell_out  [NC];
    logic [sedge_pkg::SUM_W-1:0]         cell_sum  [NC];
    logic signed [sedge_pkg::DIFF_W-1:0] cell_diff [NC];

    assign cell_in[NC-1].top = rd_pair.older;
    assign cell_in[NC-1].mid = rd_pair.newer;
    assign cell_in[NC-1].bot = s1_px_reg;

    for (genvar i = 0; i < NC; i++)
    begin : g_cells
        if (i < NC - 1)
        begin : g_link
            assign cell_in[i] = cell_out[i+1];
        end

        sedge_cell u_cell (
            .clk      (clk),
            .shift_en (s1_move),
            .col_in   (cell_in[i]),
            .col_out  (cell_out[i]),
            .col_sum  (cell_sum[i]),
            .col_diff (cell_diff[i])
        );
    end

    // ------------------------------------------------------------------
    // Stage 2: window holds the item's neighborhood.
    // ------------------------------------------------------------------
    logic  s2_valid_reg;
    meta_t s2_meta_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid_reg && s1_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_meta_reg <= s1_meta_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: horizontal and vertical gradients.
    // ------------------------------------------------------------------
    logic signed [GRAD_W-1:0] gx_next;
    logic signed [GRAD_W-1:0] gy_next;
    logic signed [GRAD_W-1:0] gx_reg;
    logic signed [GRAD_W-1:0] gy_reg;
    logic                     s3_valid_reg;
    meta_t                    s3_meta_reg;

    always_comb
    begin
        gx_next = $signed({1'b0, cell_sum[NC-1]}) - $signed({1'b0, cell_sum[0]});
        gy_next = GRAD_W'(cell_diff[0]) + (GRAD_W'(cell_diff[1]) <<< 1)
                + GRAD_W'(cell_diff[NC-1]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            gx_reg      <= gx_next;
            gy_reg      <= gy_next;
            s3_meta_reg <= s2_meta_reg;
        end
    end

    // ------------------------------------------------------------------
    // Magnitude, inversion and thresholds.
    // ------------------------------------------------------------------
    logic [GRAD_W-1:0] abs_gx;
    logic [GRAD_W-1:0] abs_gy;
    logic [GRAD_W-1:0] mag;
    logic [PW-1:0]     inv;
    result_t           res_next;

    always_comb
    begin
        abs_gx = gx_reg[GRAD_W-1] ? GRAD_W'(-gx_reg) : GRAD_W'(gx_reg);
        abs_gy = gy_reg[GRAD_W-1] ? GRAD_W'(-gy_reg) : GRAD_W'(gy_reg);
        mag    = abs_gx + abs_gy;
        inv    = ~mag[PW-1:0];

        // The high test wins when the thresholds cross.
        if (inv > high_thresh_reg)
        begin
            res_next.level = '1;
        end
        else if (inv < low_thresh_reg)
        begin
            res_next.level = '0;
        end
        else
        begin
            res_next.level = inv;
        end
        res_next.row  = s3_meta_reg.row;
        res_next.col  = s3_meta_reg.col;
        res_next.last = s3_meta_reg.last;
    end

    // ------------------------------------------------------------------
    // Output register with a one-entry skid.
    // ------------------------------------------------------------------
    result_t out_reg;
    result_t skid_reg;
    logic    new_res;
    logic    out_free;

    assign new_res  = adv && s3_valid_reg;
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_ready)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (new_res)
        begin
            if (out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_ready)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (new_res)
        begin
            if (out_free)
            begin
                out_reg <= res_next;
            end
            else
            begin
                skid_reg <= res_next;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign edge_value    = out_reg.level;
    assign center_row    = out_reg.row;
    assign center_col    = out_reg.col;
    assign last_of_frame = out_reg.last;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // The skid only ever holds a request behind a full output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a request while the output register is empty");

    // The skid fills only when the output was stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !out_ready))
        else $error("skid filled without an output stall");

    // The last pixel of a frame returns the raster position to the origin.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && frame_end) |=> (col_reg == '0 && row_reg == '0))
        else $error("raster position not cleared at end of frame");

endmodule
